// ===== rtl/ucp_pkg.sv =====
// shared widths, types and constants of the unit cross product block
package ucp_pkg;

   localparam int COMPONENT_BITS = 32;
   localparam int FRACTION_BITS  = 30;

   localparam int PROD_BITS      = 2 * COMPONENT_BITS;
   localparam int CROSS_BITS     = 2 * COMPONENT_BITS + 1;
   localparam int MAG_BITS       = 2 * COMPONENT_BITS;
   localparam int HALF_BITS      = COMPONENT_BITS;
   localparam int SQ_BITS        = 4 * COMPONENT_BITS;
   localparam int SUM_BITS       = 4 * COMPONENT_BITS + 2;
   localparam int REM_BITS       = SUM_BITS + 1;
   localparam int QUO_BITS       = 2 * FRACTION_BITS + 3;
   localparam int ROOT_BITS      = FRACTION_BITS + 2;
   localparam int RAD_BITS       = 2 * ROOT_BITS;
   localparam int SQRT_REM_BITS  = ROOT_BITS + 3;
   localparam int FRONT_STAGES   = 6;

   typedef logic signed [COMPONENT_BITS-1:0] comp_type;

   localparam comp_type UNIT_ONE = comp_type'(64'sd1 <<< FRACTION_BITS);

   typedef struct packed {
      logic valid;
      logic neg;
      logic degen;
   } tag_type;

endpackage

// ===== rtl/ucp_req_if.sv =====
// input channel: two vectors per transfer
interface ucp_req_if;
   logic              valid;
   logic              ready;
   ucp_pkg::comp_type a_x;
   ucp_pkg::comp_type a_y;
   ucp_pkg::comp_type a_z;
   ucp_pkg::comp_type b_x;
   ucp_pkg::comp_type b_y;
   ucp_pkg::comp_type b_z;

   modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
   modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

// ===== rtl/ucp_rsp_if.sv =====
// result channel: unit normal and degenerate flag per transfer
interface ucp_rsp_if;
   logic              valid;
   logic              ready;
   ucp_pkg::comp_type n_x;
   ucp_pkg::comp_type n_y;
   ucp_pkg::comp_type n_z;
   logic              degenerate;

   modport source (output valid, n_x, n_y, n_z, degenerate, input ready);
   modport sink (input valid, n_x, n_y, n_z, degenerate, output ready);
endinterface

// ===== rtl/ucp_front.sv =====
// cross product, magnitudes, squares and squared length pipeline
module ucp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  ucp_pkg::comp_type             a_vec [3],
   input  ucp_pkg::comp_type             b_vec [3],
   output ucp_pkg::tag_type              lane_tag [3],
   output logic [ucp_pkg::SQ_BITS-1:0]   sq_out [3],
   output logic [ucp_pkg::SUM_BITS-1:0]  sum_out
);
   import ucp_pkg::*;

   logic [FRONT_STAGES-1:0]        valid_ff;
   logic signed [PROD_BITS-1:0]    prod_ff [6];
   logic signed [CROSS_BITS-1:0]   cross_ff [3];
   logic [MAG_BITS-1:0]            mag_ff [3];
   logic [2:0]                     neg3_ff, neg4_ff, neg5_ff, neg6_ff;
   logic                           degen4_ff, degen5_ff, degen6_ff;
   logic [2*HALF_BITS-1:0]         ll_ff [3];
   logic [2*HALF_BITS-1:0]         lh_ff [3];
   logic [2*HALF_BITS-1:0]         hh_ff [3];
   logic [SQ_BITS-1:0]             sq5_ff [3];
   logic [SQ_BITS-1:0]             sq6_ff [3];
   logic [SUM_BITS-1:0]            sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[FRONT_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff[0] <= PROD_BITS'(a_vec[1]) * PROD_BITS'(b_vec[2]);
         prod_ff[1] <= PROD_BITS'(b_vec[1]) * PROD_BITS'(a_vec[2]);
         prod_ff[2] <= PROD_BITS'(a_vec[2]) * PROD_BITS'(b_vec[0]);
         prod_ff[3] <= PROD_BITS'(b_vec[2]) * PROD_BITS'(a_vec[0]);
         prod_ff[4] <= PROD_BITS'(a_vec[0]) * PROD_BITS'(b_vec[1]);
         prod_ff[5] <= PROD_BITS'(b_vec[0]) * PROD_BITS'(a_vec[1]);
         for (int i = 0; i < 3; i++) begin
            cross_ff[i] <= CROSS_BITS'(prod_ff[2*i]) - CROSS_BITS'(prod_ff[2*i+1]);
            neg3_ff[i]  <= cross_ff[i][CROSS_BITS-1];
            mag_ff[i]   <= MAG_BITS'(cross_ff[i][CROSS_BITS-1] ? -cross_ff[i] : cross_ff[i]);
            ll_ff[i]    <= (2*HALF_BITS)'(mag_ff[i][HALF_BITS-1:0])
                         * (2*HALF_BITS)'(mag_ff[i][HALF_BITS-1:0]);
            lh_ff[i]    <= (2*HALF_BITS)'(mag_ff[i][HALF_BITS-1:0])
                         * (2*HALF_BITS)'(mag_ff[i][MAG_BITS-1:HALF_BITS]);
            hh_ff[i]    <= (2*HALF_BITS)'(mag_ff[i][MAG_BITS-1:HALF_BITS])
                         * (2*HALF_BITS)'(mag_ff[i][MAG_BITS-1:HALF_BITS]);
            sq5_ff[i]   <= {hh_ff[i], ll_ff[i]} + (SQ_BITS'(lh_ff[i]) << (HALF_BITS + 1));
            sq6_ff[i]   <= sq5_ff[i];
         end
         neg4_ff   <= neg3_ff;
         neg5_ff   <= neg4_ff;
         neg6_ff   <= neg5_ff;
         degen4_ff <= (mag_ff[0] == '0) && (mag_ff[1] == '0) && (mag_ff[2] == '0);
         degen5_ff <= degen4_ff;
         degen6_ff <= degen5_ff;
         sum_ff    <= SUM_BITS'(sq5_ff[0]) + SUM_BITS'(sq5_ff[1]) + SUM_BITS'(sq5_ff[2]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lane_tag[i].valid = valid_ff[FRONT_STAGES-1];
         lane_tag[i].neg   = neg6_ff[i];
         lane_tag[i].degen = degen6_ff;
         sq_out[i]         = sq6_ff[i];
      end
      sum_out = sum_ff;
   end

endmodule

// ===== rtl/ucp_div.sv =====
// restoring divider, one quotient bit per stage: floor(sq * 4^(frac+1) / sum)
module ucp_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  ucp_pkg::tag_type              tag_in,
   input  logic [ucp_pkg::SQ_BITS-1:0]   sq_in,
   input  logic [ucp_pkg::SUM_BITS-1:0]  sum_in,
   output ucp_pkg::tag_type              tag_out,
   output logic [ucp_pkg::QUO_BITS-1:0]  quo_out
);
   import ucp_pkg::*;

   tag_type               tag_ff  [QUO_BITS];
   logic [QUO_BITS-1:0]   quo_ff  [QUO_BITS];
   logic [REM_BITS-1:0]   rem_ff  [QUO_BITS-1];
   logic [SUM_BITS-1:0]   sum_ff  [QUO_BITS-1];

   tag_type               tag_src [QUO_BITS];
   logic [QUO_BITS-1:0]   quo_src [QUO_BITS];
   logic [REM_BITS-1:0]   rem_src [QUO_BITS];
   logic [SUM_BITS-1:0]   sum_src [QUO_BITS];

   always_comb begin
      tag_src[0] = tag_in;
      quo_src[0] = '0;
      rem_src[0] = REM_BITS'(sq_in);
      sum_src[0] = sum_in;
      for (int j = 1; j < QUO_BITS; j++) begin
         tag_src[j] = tag_ff[j-1];
         quo_src[j] = quo_ff[j-1];
         rem_src[j] = rem_ff[j-1];
         sum_src[j] = sum_ff[j-1];
      end
   end

   for (genvar j = 0; j < QUO_BITS; j++) begin : g_stage
      logic                ge;
      logic [REM_BITS-1:0] diff;

      assign ge   = rem_src[j] >= REM_BITS'(sum_src[j]);
      assign diff = ge ? rem_src[j] - REM_BITS'(sum_src[j]) : rem_src[j];

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[j] <= '0;
         end else if (en) begin
            tag_ff[j] <= tag_src[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[j] <= {quo_src[j][QUO_BITS-2:0], ge};
         end
      end

      if (j < QUO_BITS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= diff << 1;
               sum_ff[j] <= sum_src[j];
            end
         end
      end
   end

   assign tag_out = tag_ff[QUO_BITS-1];
   assign quo_out = quo_ff[QUO_BITS-1];

endmodule

// ===== rtl/ucp_sqrt.sv =====
// restoring integer square root, one root bit per stage
module ucp_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  ucp_pkg::tag_type               tag_in,
   input  logic [ucp_pkg::QUO_BITS-1:0]   quo_in,
   output ucp_pkg::tag_type               tag_out,
   output logic [ucp_pkg::ROOT_BITS-1:0]  root_out
);
   import ucp_pkg::*;

   tag_type                  tag_ff   [ROOT_BITS];
   logic [ROOT_BITS-1:0]     root_ff  [ROOT_BITS];
   logic [SQRT_REM_BITS-1:0] rem_ff   [ROOT_BITS-1];
   logic [RAD_BITS-1:0]      rad_ff   [ROOT_BITS-1];

   tag_type                  tag_src  [ROOT_BITS];
   logic [ROOT_BITS-1:0]     root_src [ROOT_BITS];
   logic [SQRT_REM_BITS-1:0] rem_src  [ROOT_BITS];
   logic [RAD_BITS-1:0]      rad_src  [ROOT_BITS];

   always_comb begin
      tag_src[0]  = tag_in;
      root_src[0] = '0;
      rem_src[0]  = '0;
      rad_src[0]  = RAD_BITS'(quo_in);
      for (int j = 1; j < ROOT_BITS; j++) begin
         tag_src[j]  = tag_ff[j-1];
         root_src[j] = root_ff[j-1];
         rem_src[j]  = rem_ff[j-1];
         rad_src[j]  = rad_ff[j-1];
      end
   end

   for (genvar j = 0; j < ROOT_BITS; j++) begin : g_stage
      logic                     ge;
      logic [SQRT_REM_BITS-1:0] cur;
      logic [SQRT_REM_BITS-1:0] trial;

      assign cur   = {rem_src[j][SQRT_REM_BITS-3:0], rad_src[j][RAD_BITS-1 -: 2]};
      assign trial = SQRT_REM_BITS'({root_src[j], 2'b01});
      assign ge    = cur >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[j] <= '0;
         end else if (en) begin
            tag_ff[j] <= tag_src[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[j] <= {root_src[j][ROOT_BITS-2:0], ge};
         end
      end

      if (j < ROOT_BITS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= ge ? cur - trial : cur;
               rad_ff[j] <= rad_src[j] << 2;
            end
         end
      end
   end

   assign tag_out  = tag_ff[ROOT_BITS-1];
   assign root_out = root_ff[ROOT_BITS-1];

endmodule

// ===== rtl/unit_cross_product_top.sv =====
// unit cross product: normalized a x b in signed Q1.30
//
// req_if carries two 3-D vectors a and b per transfer, rsp_if carries the
// unit normal n = (a x b) / |a x b| rounded to nearest, ties away from zero,
// plus a degenerate flag. a zero cross product gives n = 0 and degenerate = 1.
// one transfer is taken every cycle while req_if.ready is high; results leave in input order.
// the pipeline holds 6 stages of products, magnitudes and squared length,
// 63 stages of the restoring divider (one quotient bit each), 32 stages of
// the square root (one root bit each) and the output register.
// the whole pipeline advances when the output register is empty or its
// result is being taken; while the receiver holds rsp_if.ready low with a
// result waiting, req_if.ready is low and every stage holds its contents.
// reset clears the valid bits of all stages; no data is lost or repeated.
module unit_cross_product_top (
   input  logic       clock,
   input  logic       reset,
   ucp_req_if.sink    req_if,
   ucp_rsp_if.source  rsp_if
);
   import ucp_pkg::*;

   logic                 en;
   comp_type             a_vec [3];
   comp_type             b_vec [3];
   tag_type              front_tag [3];
   logic [SQ_BITS-1:0]   front_sq [3];
   logic [SUM_BITS-1:0]  front_sum;
   tag_type              div_tag [3];
   logic [QUO_BITS-1:0]  div_quo [3];
   tag_type              root_tag [3];
   logic [ROOT_BITS-1:0] root_val [3];
   comp_type             n_in [3];

   logic                 rsp_valid_ff;
   comp_type             n_ff [3];
   logic                 degen_ff;

   assign en           = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = en;

   assign a_vec[0] = req_if.a_x;
   assign a_vec[1] = req_if.a_y;
   assign a_vec[2] = req_if.a_z;
   assign b_vec[0] = req_if.b_x;
   assign b_vec[1] = req_if.b_y;
   assign b_vec[2] = req_if.b_z;

   ucp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_if.valid),
      .a_vec    (a_vec),
      .b_vec    (b_vec),
      .lane_tag (front_tag),
      .sq_out   (front_sq),
      .sum_out  (front_sum)
   );

   for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [ROOT_BITS:0]   q_sum;
      comp_type             q_mag;

      ucp_div u_div (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .tag_in  (front_tag[i]),
         .sq_in   (front_sq[i]),
         .sum_in  (front_sum),
         .tag_out (div_tag[i]),
         .quo_out (div_quo[i])
      );

      ucp_sqrt u_sqrt (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .tag_in   (div_tag[i]),
         .quo_in   (div_quo[i]),
         .tag_out  (root_tag[i]),
         .root_out (root_val[i])
      );

      // round half away: q = (m + 1) / 2
      assign q_sum = (ROOT_BITS+1)'(root_val[i]) + (ROOT_BITS+1)'(1);
      assign q_mag = COMPONENT_BITS'(q_sum[ROOT_BITS:1]);
      assign n_in[i] = root_tag[i].degen ? '0 : (root_tag[i].neg ? -q_mag : q_mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= root_tag[0].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff     <= n_in;
         degen_ff <= root_tag[0].degen;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.n_x        = n_ff[0];
   assign rsp_if.n_y        = n_ff[1];
   assign rsp_if.n_z        = n_ff[2];
   assign rsp_if.degenerate = degen_ff;

   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.degenerate |->
         rsp_if.n_x == '0 && rsp_if.n_y == '0 && rsp_if.n_z == '0)
      else $error("degenerate result with nonzero normal");

   a_normal_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.degenerate |->
         !(rsp_if.n_x == '0 && rsp_if.n_y == '0 && rsp_if.n_z == '0))
      else $error("nondegenerate result with zero normal");

   a_normal_range : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |->
         rsp_if.n_x <= UNIT_ONE && rsp_if.n_x >= -UNIT_ONE &&
         rsp_if.n_y <= UNIT_ONE && rsp_if.n_y >= -UNIT_ONE &&
         rsp_if.n_z <= UNIT_ONE && rsp_if.n_z >= -UNIT_ONE)
      else $error("normal component beyond unit magnitude");

endmodule

// ===== tb/tb_unit_cross_product_top.sv =====
// testbench for unit_cross_product_top: directed table plus random vectors, checked by predictor
`timescale 1ns / 1ps

module tb_unit_cross_product_top;
   import ucp_pkg::*;

   typedef struct {
      comp_type a_x, a_y, a_z, b_x, b_y, b_z;
   } vec_pair_type;

   typedef struct {
      comp_type n_x, n_y, n_z;
      logic     degenerate;
   } normal_type;

   typedef struct {
      vec_pair_type pair;
      bit           typed;
      normal_type   want;
   } stim_row_type;

   localparam comp_type MAX_C = 32'sh7fff_ffff;
   localparam comp_type MIN_C = 32'sh8000_0000;
   localparam int RANDOM_ITEMS = 1000;
   localparam int WATCHDOG_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ucp_req_if req_if ();
   ucp_rsp_if rsp_if ();

   unit_cross_product_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   stim_row_type stim_q[$];
   normal_type   normal_q[$];
   int           next_idx = 0;
   int           send_idle = 24;
   int           recv_idle = 59;
   bit           hold_off = 1'b0;
   int           mismatches = 0;
   int           quiet_cycles = 0;
   bit           cur_typed;
   normal_type   cur_want;

   function automatic normal_type unit_normal(vec_pair_type p);
      logic signed [65:0] va[3], vb[3], c[3];
      logic [255:0] sq[3], sum, rhs, lhs, d;
      logic [31:0]  q, t;
      normal_type r;
      va[0] = p.a_x; va[1] = p.a_y; va[2] = p.a_z;
      vb[0] = p.b_x; vb[1] = p.b_y; vb[2] = p.b_z;
      c[0] = va[1] * vb[2] - vb[1] * va[2];
      c[1] = va[2] * vb[0] - vb[2] * va[0];
      c[2] = va[0] * vb[1] - vb[0] * va[1];
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         sq[i] = 256'(c[i] < 0 ? -c[i] : c[i]);
         sq[i] = sq[i] * sq[i];
         sum = sum + sq[i];
      end
      r = '{default: '0};
      if (sum == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      for (int i = 0; i < 3; i++) begin
         rhs = sq[i] << (2 * FRACTION_BITS + 2);
         q = '0;
         for (int b = FRACTION_BITS; b >= 0; b--) begin
            t = q | (32'd1 << b);
            if (t > (32'd1 << FRACTION_BITS)) continue;
            d = 256'(2 * t - 1);
            lhs = d * d * sum;
            if (lhs <= rhs) q = t;
         end
         if (c[i] < 0) q = -q;
         if (i == 0) r.n_x = q;
         else if (i == 1) r.n_y = q;
         else r.n_z = q;
      end
      return r;
   endfunction

   function automatic comp_type pick_extreme();
      case ($urandom_range(6))
         0: return MAX_C;
         1: return MIN_C;
         2: return 0;
         3: return 1;
         4: return -1;
         5: return UNIT_ONE;
         default: return -UNIT_ONE;
      endcase
   endfunction

   function automatic vec_pair_type rand_pair();
      vec_pair_type p;
      p.a_x = $urandom; p.a_y = $urandom; p.a_z = $urandom;
      p.b_x = $urandom; p.b_y = $urandom; p.b_z = $urandom;
      case ($urandom_range(9))
         4: begin
            p.a_x = $signed($urandom_range(2000)) - 1000;
            p.a_y = $signed($urandom_range(2000)) - 1000;
            p.a_z = $signed($urandom_range(2000)) - 1000;
            p.b_x = $signed($urandom_range(2000)) - 1000;
            p.b_y = $signed($urandom_range(2000)) - 1000;
            p.b_z = $signed($urandom_range(2000)) - 1000;
         end
         5: begin
            p.b_x = p.a_x; p.b_y = p.a_y; p.b_z = p.a_z;
         end
         6: begin
            p.a_x = pick_extreme(); p.a_y = pick_extreme(); p.a_z = pick_extreme();
            p.b_x = pick_extreme(); p.b_y = pick_extreme(); p.b_z = pick_extreme();
         end
         7: begin
            p.a_y = 0; p.a_z = 0;
         end
         8: begin
            p.a_x = p.a_x >>> 1; p.a_y = p.a_y >>> 1; p.a_z = p.a_z >>> 1;
            p.b_x = p.b_x >>> 1; p.b_y = p.b_y >>> 1; p.b_z = p.b_z >>> 1;
         end
         9: begin
            p.a_x = pick_extreme(); p.b_z = pick_extreme();
         end
         default: ;
      endcase
      return p;
   endfunction

   task automatic add_row(input comp_type ax, ay, az, bx, by, bz, input bit typed,
                          input comp_type nx = 0, ny = 0, nz = 0, input logic dg = 1'b0);
      stim_row_type r;
      r.pair = '{ax, ay, az, bx, by, bz};
      r.typed = typed;
      r.want = '{nx, ny, nz, dg};
      stim_q.push_back(r);
   endtask

   initial begin
      add_row(UNIT_ONE, 0, 0, 0, UNIT_ONE, 0, 1, 0, 0, UNIT_ONE);
      add_row(0, UNIT_ONE, 0, UNIT_ONE, 0, 0, 1, 0, 0, -UNIT_ONE);
      add_row(0, UNIT_ONE, 0, 0, 0, UNIT_ONE, 1, UNIT_ONE, 0, 0);
      add_row(0, 0, UNIT_ONE, UNIT_ONE, 0, 0, 1, 0, UNIT_ONE, 0);
      add_row(1, 0, 0, 0, 0, 1, 1, 0, -UNIT_ONE, 0);
      add_row(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1'b1);
      add_row(MAX_C, MIN_C, 5, MAX_C, MIN_C, 5, 1, 0, 0, 0, 1'b1);
      add_row(MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, 1, 0, 0, 0, 1'b1);
      add_row(1, 2, 3, -1, -2, -3, 1, 0, 0, 0, 1'b1);
      add_row(MIN_C, 0, 0, 0, MIN_C, 0, 1, 0, 0, UNIT_ONE);
      add_row(MAX_C, 0, 0, 0, MIN_C, 0, 1, 0, 0, -UNIT_ONE);
      add_row(MAX_C, 0, 0, 0, MAX_C, 0, 1, 0, 0, UNIT_ONE);
      add_row(MAX_C, MAX_C, MAX_C, MIN_C, 0, MAX_C, 0);
      add_row(MIN_C, MIN_C, MIN_C, MAX_C, 0, MIN_C, 0);
      add_row(MAX_C, MIN_C, MAX_C, MIN_C, MAX_C, 0, 0);
      add_row(1, 1, 0, 0, 0, 1, 0);
      add_row(3, 4, 0, 0, 0, 1, 0);
      add_row(-1, -1, -1, 1, -1, 0, 0);
      add_row(UNIT_ONE, UNIT_ONE, UNIT_ONE, -UNIT_ONE, UNIT_ONE, MIN_C, 0);
      add_row(1, 0, 0, 0, 1, 1, 0);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         stim_row_type r;
         r.pair = rand_pair();
         r.typed = 0;
         stim_q.push_back(r);
      end
   end

   // sender: record each transfer, then offer the next row
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.a_x <= '0; req_if.a_y <= '0; req_if.a_z <= '0;
         req_if.b_x <= '0; req_if.b_y <= '0; req_if.b_z <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            if (cur_typed) normal_q.push_back(cur_want);
            else normal_q.push_back(unit_normal('{req_if.a_x, req_if.a_y, req_if.a_z,
                                                  req_if.b_x, req_if.b_y, req_if.b_z}));
         end
         if (!req_if.valid || req_if.ready) begin
            if (next_idx < stim_q.size() && $urandom_range(99) >= send_idle) begin
               req_if.a_x <= stim_q[next_idx].pair.a_x;
               req_if.a_y <= stim_q[next_idx].pair.a_y;
               req_if.a_z <= stim_q[next_idx].pair.a_z;
               req_if.b_x <= stim_q[next_idx].pair.b_x;
               req_if.b_y <= stim_q[next_idx].pair.b_y;
               req_if.b_z <= stim_q[next_idx].pair.b_z;
               cur_typed = stim_q[next_idx].typed;
               cur_want = stim_q[next_idx].want;
               req_if.valid <= 1'b1;
               next_idx++;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: compare each transfer with the oldest expected normal
   always @(posedge clock) begin
      normal_type w;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (normal_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result n=(%0d,%0d,%0d) degenerate=%0b",
                           rsp_if.n_x, rsp_if.n_y, rsp_if.n_z, rsp_if.degenerate);
            end else begin
               w = normal_q.pop_front();
               if (rsp_if.n_x !== w.n_x || rsp_if.n_y !== w.n_y || rsp_if.n_z !== w.n_z
                   || rsp_if.degenerate !== w.degenerate) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected (%0d,%0d,%0d) deg %0b, got (%0d,%0d,%0d) deg %0b",
                              w.n_x, w.n_y, w.n_z, w.degenerate,
                              rsp_if.n_x, rsp_if.n_y, rsp_if.n_z, rsp_if.degenerate);
               end
            end
         end
         rsp_if.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
      end
   end

   // idling phases by progress through the stimulus
   always @(posedge clock) begin
      if (next_idx >= 2 * stim_q.size() / 3 && stim_q.size() > 0) begin
         send_idle = 0;
         recv_idle = 0;
      end else if (next_idx >= stim_q.size() / 3 && stim_q.size() > 0) begin
         send_idle = 59;
         recv_idle = 24;
      end
   end

   // long receiver stall while the sender keeps offering
   initial begin
      wait (!reset && stim_q.size() > 0 && next_idx >= 2 * stim_q.size() / 3 + 20);
      hold_off = 1'b1;
      repeat (400) @(posedge clock);
      hold_off = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_unit_cross_product_top: done, errors");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (stim_q.size() > 0 && next_idx == stim_q.size());
      @(posedge clock);
      while (req_if.valid || normal_q.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (mismatches == 0 && normal_q.size() == 0) begin
         $display("tb_unit_cross_product_top: done, clean");
      end else begin
         $display("tb_unit_cross_product_top: done, errors");
      end
      $finish;
   end

endmodule
